// ===== sv/itl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itl_pkg: shared types and constants for the interpolation table
// Beat payload structs, status codes and the default table depth.
// ----------------------------------------------------------------------------
package itl_pkg;

  localparam int unsigned DEPTH_DEF = 64;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_INTERP   = 3'd0,
    ST_CLAMP_LO = 3'd1,
    ST_CLAMP_HI = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_INSERTED = 3'd4,
    ST_REPLACED = 3'd5,
    ST_FULL     = 3'd6
  } status_t;

  typedef struct packed {
    logic               op;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         status;
  } out_beat_t;

endpackage

// ===== sv/interp_table_lookup_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interp_table_lookup_unit: piecewise linear interpolation table
// Sorted breakpoint store with insert/replace and interpolating queries.
// ----------------------------------------------------------------------------
// One beat is worked on at a time; in_stall is high from acceptance until the
// result beat has been placed in the output register. A beat first runs a
// binary search over the key memory, each probe a registered read and then a
// compare. An insert of a new key into a table that is not full then moves
// every entry above its place up by one, each entry read and then written,
// through the single memory port. A query that lands between two breakpoints
// reads its neighbour words, forms the 64-bit product from two 32x16 partial
// products, and runs a restoring divider that yields one quotient bit per
// cycle. The result is built in working registers and only copied into the
// output register when that register is free, so the next beat may start
// while a result beat still waits for the receiver. The stores are memories
// whose contents are undefined until written; only entries below the fill
// count are ever used, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module interp_table_lookup_unit #(
  parameter int unsigned DEPTH = itl_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  itl_pkg::in_beat_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output itl_pkg::out_beat_t out_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_SRD   = 14'b00000000000010,  // search: issue probe read
    S_SCMP  = 14'b00000000000100,  // search: compare probed key
    S_DEC   = 14'b00000000001000,
    S_CHKRD = 14'b00000000010000,  // read key just below the place
    S_CHK   = 14'b00000000100000,
    S_MVRD  = 14'b00000001000000,  // read entry to move up
    S_MVWR  = 14'b00000010000000,
    S_INS   = 14'b00000100000000,
    S_NBRD  = 14'b00001000000000,  // read neighbour words
    S_MUL   = 14'b00010000000000,
    S_DIV   = 14'b00100000000000,
    S_FIN   = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] key_mem [DEPTH];
  logic [31:0] val_mem [DEPTH];
  logic [31:0] key_rd_r, val_rd_r;

  logic [CW-1:0] count_r;
  logic [CW-1:0] lo_r, hi_r;
  logic [CW-1:0] ptr_r;
  logic [2:0]    step_r;
  logic [6:0]    div_cnt_r;
  itl_pkg::in_beat_t beat_r;
  logic signed [31:0] klo_r, kup_r, vlo_r, vup_r;
  logic [31:0]   dx_r, dk_r, mag_r;
  logic          neg_r;
  logic [63:0]   prod_r;   // product, then quotient bits shift in
  logic [32:0]   rem_r;
  itl_pkg::out_beat_t res_r;
  logic          out_valid_r;
  itl_pkg::out_beat_t out_data_r;

  // Memory port controls
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wkey, mem_wval;

  logic [CW-1:0] mid;
  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  logic [32:0] rem_sh;
  logic [33:0] rem_sub;
  assign rem_sh  = {rem_r[31:0], prod_r[63]};
  assign rem_sub = {1'b0, rem_sh} - {2'b00, dk_r};

  logic [47:0] pp;
  assign pp = mag_r * (step_r[0] ? dx_r[15:0] : dx_r[31:16]);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_waddr] <= mem_wkey;
      val_mem[mem_waddr] <= mem_wval;
    end
    key_rd_r <= key_mem[mem_raddr];
    val_rd_r <= val_mem[mem_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_waddr = ptr_r[AW-1:0];
    mem_raddr = ptr_r[AW-1:0];
    mem_wkey  = key_rd_r;
    mem_wval  = val_rd_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SRD;
      S_SRD: begin
        mem_raddr = mid[AW-1:0];
        state_nxt = (lo_r < hi_r) ? S_SCMP : S_DEC;
      end
      S_SCMP:  state_nxt = S_SRD;
      S_DEC:   state_nxt = S_CHKRD;
      S_CHKRD: state_nxt = S_CHK;
      S_CHK:   ;
      S_MVRD:  state_nxt = S_MVWR;
      S_MVWR: begin
        mem_we    = 1'b1;
        state_nxt = S_MVRD;
      end
      S_INS: begin
        mem_we   = 1'b1;
        mem_wkey = beat_r.key;
        mem_wval = beat_r.value;
        state_nxt = S_OUT;
      end
      S_NBRD:  ;
      S_MUL:   ;
      S_DIV:   ;
      S_FIN:   state_nxt = S_OUT;
      S_OUT:   if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    // Sequencer decisions that depend on data
    unique case (state_r)
      S_DEC: begin
        if (beat_r.op == itl_pkg::OP_QUERY) begin
          if (count_r == '0 || lo_r == count_r || lo_r == '0) state_nxt = S_FIN;
          else state_nxt = S_NBRD;
        end else if (lo_r == '0) begin
          state_nxt = (count_r == CW'(DEPTH)) ? S_FIN : S_MVRD;
        end
        // A low clamp needs the first entry, every other case the one below
        // the place found by the search.
        mem_raddr = (lo_r == '0) ? '0 : AW'(lo_r - 1'b1);
      end
      S_CHKRD: mem_raddr = AW'(lo_r - 1'b1);
      S_CHK: begin
        if ($signed(key_rd_r) == beat_r.key) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(lo_r - 1'b1);
          mem_wkey  = key_rd_r;
          mem_wval  = beat_r.value;
          state_nxt = S_OUT;
        end else if (count_r == CW'(DEPTH)) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_MVRD;
        end
      end
      S_MVRD: begin
        mem_raddr = AW'(ptr_r - 1'b1);
        if (ptr_r == lo_r) state_nxt = S_INS;
      end
      S_NBRD: begin
        mem_raddr = step_r[1] ? lo_r[AW-1:0] : AW'(lo_r - 1'b1);
        if (step_r == 3'd4) state_nxt = S_MUL;
      end
      S_MUL:   if (step_r == 3'd3) state_nxt = S_DIV;
      S_DIV:   if (div_cnt_r == 7'd63) state_nxt = S_FIN;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_INS) count_r <= count_r + 1'b1;
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        beat_r <= in_data;
        lo_r   <= '0;
        hi_r   <= count_r;
        step_r <= '0;
        div_cnt_r <= '0;
      end
      S_SRD:  ptr_r <= mid;
      S_SCMP: begin
        if ($signed(key_rd_r) > beat_r.key) hi_r <= ptr_r;
        else lo_r <= ptr_r + 1'b1;
      end
      S_DEC: begin
        ptr_r <= count_r;
        res_r.result_value <= '0;
        if (beat_r.op == itl_pkg::OP_QUERY) begin
          res_r.status <= (count_r == '0) ? itl_pkg::ST_EMPTY :
                          (lo_r == count_r) ? itl_pkg::ST_CLAMP_HI :
                          (lo_r == '0) ? itl_pkg::ST_CLAMP_LO : itl_pkg::ST_INTERP;
          // Clamp reads the end entry through the ordinary read path
        end else begin
          res_r.status <= (count_r == CW'(DEPTH)) ? itl_pkg::ST_FULL :
                          itl_pkg::ST_INSERTED;
        end
      end
      S_CHK: res_r.status <= ($signed(key_rd_r) == beat_r.key) ?
                             itl_pkg::ST_REPLACED :
                             (count_r == CW'(DEPTH)) ? itl_pkg::ST_FULL :
                             itl_pkg::ST_INSERTED;
      S_MVWR: ptr_r <= ptr_r - 1'b1;
      S_NBRD: begin
        step_r <= (step_r == 3'd4) ? '0 : step_r + 1'b1;
        if (step_r == 3'd2) begin
          klo_r <= key_rd_r;
          vlo_r <= val_rd_r;
        end
        if (step_r == 3'd3) begin
          kup_r <= key_rd_r;
          vup_r <= val_rd_r;
        end
        if (step_r == 3'd4) begin
          dx_r   <= 32'(beat_r.key - klo_r);
          dk_r   <= 32'(kup_r - klo_r);
          neg_r  <= (vup_r < vlo_r);
          mag_r  <= (vup_r < vlo_r) ? 32'(vlo_r - vup_r) : 32'(vup_r - vlo_r);
          prod_r <= '0;
        end
      end
      S_MUL: begin
        step_r <= step_r + 1'b1;
        if (step_r == 3'd1) prod_r <= {16'd0, pp};
        if (step_r == 3'd2) prod_r <= prod_r + {pp, 16'd0};
        if (step_r == 3'd0) prod_r <= '0;
        rem_r <= '0;
      end
      S_DIV: begin
        div_cnt_r <= div_cnt_r + 1'b1;
        if (!rem_sub[33]) begin
          rem_r  <= rem_sub[32:0];
          prod_r <= {prod_r[62:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          prod_r <= {prod_r[62:0], 1'b0};
        end
      end
      S_FIN: begin
        if (res_r.status == itl_pkg::ST_INTERP)
          res_r.result_value <= neg_r ? vlo_r - $signed(prod_r[31:0]) :
                                        vlo_r + $signed(prod_r[31:0]);
        else if (res_r.status == itl_pkg::ST_CLAMP_LO ||
                 res_r.status == itl_pkg::ST_CLAMP_HI)
          res_r.result_value <= val_rd_r;
      end
      S_OUT: if (!out_valid_r || !out_stall) out_data_r <= res_r;
      default: ;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accepting while busy");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("fill count beyond depth");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_data)) else $error("result beat changed");

endmodule
